FILE: hdl/fdl_pkg.sv
// Shared types, codes and helpers for the force-directed layout step engine.
// Depends on nothing; imported by force_directed_layout_step and its testbench.
package fdl_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int DEF_MAX_NODES = 64;
  localparam int DIV_W         = 32 + FRAC_BITS;
  localparam int UNIT_W        = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    FN_WRITE_POS = 2'd0,
    FN_WRITE_LEN = 2'd1,
    FN_STEP      = 2'd2,
    FN_READ      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    CFG_NODE_COUNT = 3'd0,
    CFG_REPULSION  = 3'd1,
    CFG_SPRING     = 3'd2,
    CFG_TIME_STEP  = 3'd3,
    CFG_DRAG       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic               sat;
  } node_t;

  typedef struct packed {
    logic        mark;
    logic [30:0] rest;
  } edge_t;

  // {overflow, value} of v clamped to 32-bit signed
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

FILE: hdl/force_directed_layout_step.sv
// Force-directed layout step engine: node and rest-length memories, one shared
// multiplier, bit-serial square root and a shared bit-serial divider.
// A step takes a square root and four divides per ordered node pair, then
// integrates each node in turn and emits its new position.
// Reset: a clearing pass over every rest-length address zeroes both memories;
// no item is accepted during it, configuration writes still are.
module force_directed_layout_step import fdl_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_node_index,
  input  logic [5:0]         in_peer_index,
  input  logic signed [31:0] in_pos_x_in,
  input  logic signed [31:0] in_pos_y_in,
  input  logic [30:0]        in_rest_len_in,
  input  logic               in_edge_present,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_node,
  output logic signed [31:0] out_pos_x_out,
  output logic signed [31:0] out_pos_y_out,
  output logic               out_saturated,
  output logic               out_last
);

  localparam int IW     = $clog2(MAX_NODES);
  localparam int NW     = $clog2(MAX_NODES + 1);
  localparam int EW     = 2 * IW;
  localparam int EDEPTH = 1 << EW;
  localparam int ACC_W  = 33 + IW;
  localparam int DCW    = $clog2(DIV_W);

  localparam logic [1:0] DOP_Q1 = 2'd0;
  localparam logic [1:0] DOP_Q2 = 2'd1;
  localparam logic [1:0] DOP_UX = 2'd2;
  localparam logic [1:0] DOP_UY = 2'd3;

  localparam logic [2:0] IOP_DRAG_X = 3'd0;
  localparam logic [2:0] IOP_DT_X   = 3'd1;
  localparam logic [2:0] IOP_DRAG_Y = 3'd2;
  localparam logic [2:0] IOP_DT_Y   = 3'd3;
  localparam logic [2:0] IOP_ACC_X  = 3'd4;
  localparam logic [2:0] IOP_ACC_Y  = 3'd5;
  localparam logic [2:0] IOP_POS_X  = 3'd6;
  localparam logic [2:0] IOP_POS_Y  = 3'd7;

  typedef enum logic [24:0] {
    ST_CLEAR   = 25'd1 << 0,
    ST_IDLE    = 25'd1 << 1,
    ST_RD_EMIT = 25'd1 << 2,
    ST_F_RDI   = 25'd1 << 3,
    ST_F_LATI  = 25'd1 << 4,
    ST_F_RDJ   = 25'd1 << 5,
    ST_F_DIFF  = 25'd1 << 6,
    ST_F_SQX   = 25'd1 << 7,
    ST_F_SQY   = 25'd1 << 8,
    ST_F_SUM   = 25'd1 << 9,
    ST_F_CHK   = 25'd1 << 10,
    ST_F_SQRT  = 25'd1 << 11,
    ST_F_DIV   = 25'd1 << 12,
    ST_F_SPDIF = 25'd1 << 13,
    ST_F_SPMUL = 25'd1 << 14,
    ST_F_SPRES = 25'd1 << 15,
    ST_F_AXMUL = 25'd1 << 16,
    ST_F_AYMUL = 25'd1 << 17,
    ST_F_AYRES = 25'd1 << 18,
    ST_F_WRI   = 25'd1 << 19,
    ST_I_RD    = 25'd1 << 20,
    ST_I_DAT   = 25'd1 << 21,
    ST_I_MUL   = 25'd1 << 22,
    ST_I_RES   = 25'd1 << 23,
    ST_I_EMIT  = 25'd1 << 24
  } state_t;

  state_t state_r, state_nxt;

  // memories
  node_t nm_mem [MAX_NODES];
  edge_t em_mem [EDEPTH];
  node_t nm_rd_r;
  edge_t em_rd_r;
  logic  nm_we, em_we;
  logic [IW-1:0] nm_raddr, nm_waddr;
  logic [EW-1:0] em_raddr, em_waddr;
  node_t nm_wdata;
  edge_t em_wdata;

  // configuration
  logic [6:0]         nc_r;
  logic signed [31:0] rep_r, spr_r;
  logic [30:0]        dt_r, drag_r;

  // control and datapath
  logic [EW-1:0]      clr_r;
  logic [IW-1:0]      i_r, j_r;
  logic [5:0]         req_node_r;
  logic               req_ok_r;
  node_t              node_i_r, work_r;
  edge_t              edge_r;
  logic signed [31:0] dx_r, dy_r, f2_r, diff_r, tot_r, tmp_r;
  logic [63:0]        d2_r, sq_x_r, sq_y_r, sq_bit_r;
  logic [31:0]        dist_r;
  logic [32:0]        rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [DCW-1:0]     div_cnt_r;
  logic [1:0]         dop_r;
  logic [UNIT_W-1:0]  ux_r, uy_r;
  logic signed [ACC_W-1:0] ax_acc_r, ay_acc_r;
  logic               fl_r;
  logic [2:0]         iop_r;
  logic [63:0]        prod_r;
  logic               pneg_r;

  logic               out_valid_r, out_sat_r, out_last_r;
  logic [5:0]         out_node_r;
  logic signed [31:0] out_px_r, out_py_r;

  // combinational
  logic               in_acc, ni_ok, pj_ok, out_free, load_out;
  logic [NW-1:0]      n_eff;
  logic [IW-1:0]      last_idx;
  logic               i_last, j_last;
  logic [31:0]        mul_a, mul_b;
  logic               mul_neg;
  logic [63:0]        prod_sh;
  logic signed [63:0] mq;
  logic [32:0]        ms, sx, sy, f2s, dfs, f1s, tts, axs, ays, irs;
  logic [63:0]        sq_t, sq_x_n, sq_y_n;
  logic               sq_ge;
  logic [32:0]        rem_sh, rem_n;
  logic               d_ge, div_done;
  logic [DIV_W-1:0]   quo_n;
  logic [31:0]        q1c;
  logic signed [31:0] f1v, irs_base;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign ni_ok     = (32'(in_node_index) < MAX_NODES);
  assign pj_ok     = (32'(in_peer_index) < MAX_NODES);
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (state_r == ST_RD_EMIT || state_r == ST_I_EMIT) && out_free;

  always_comb begin
    if (nc_r == 7'd0) begin
      n_eff = NW'(1);
    end else if (32'(nc_r) > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(nc_r);
    end
  end
  assign last_idx = IW'(n_eff - NW'(1));
  assign i_last   = (i_r == last_idx);
  assign j_last   = (j_r == last_idx);

  // shared multiplier operand select
  always_comb begin
    mul_a   = mag32(dx_r);
    mul_b   = mag32(dx_r);
    mul_neg = 1'b0;
    case (state_r)
      ST_F_SQY: begin
        mul_a = mag32(dy_r);
        mul_b = mag32(dy_r);
      end
      ST_F_SPMUL: begin
        mul_a   = mag32(spr_r);
        mul_b   = mag32(diff_r);
        mul_neg = spr_r[31] ^ diff_r[31];
      end
      ST_F_AXMUL: begin
        mul_a   = 32'(ux_r);
        mul_b   = mag32(tot_r);
        mul_neg = dx_r[31] ^ tot_r[31];
      end
      ST_F_AYMUL: begin
        mul_a   = 32'(uy_r);
        mul_b   = mag32(tot_r);
        mul_neg = dy_r[31] ^ tot_r[31];
      end
      ST_I_MUL: begin
        case (iop_r)
          IOP_DRAG_X: begin
            mul_a = {1'b0, drag_r}; mul_b = mag32(work_r.vx); mul_neg = work_r.vx[31];
          end
          IOP_DRAG_Y: begin
            mul_a = {1'b0, drag_r}; mul_b = mag32(work_r.vy); mul_neg = work_r.vy[31];
          end
          IOP_DT_X, IOP_DT_Y: begin
            mul_a = mag32(tmp_r); mul_b = {1'b0, dt_r}; mul_neg = tmp_r[31];
          end
          IOP_ACC_X: begin
            mul_a = mag32(work_r.ax); mul_b = {1'b0, dt_r}; mul_neg = work_r.ax[31];
          end
          IOP_ACC_Y: begin
            mul_a = mag32(work_r.ay); mul_b = {1'b0, dt_r}; mul_neg = work_r.ay[31];
          end
          IOP_POS_X: begin
            mul_a = mag32(work_r.vx); mul_b = {1'b0, dt_r}; mul_neg = work_r.vx[31];
          end
          default: begin
            mul_a = mag32(work_r.vy); mul_b = {1'b0, dt_r}; mul_neg = work_r.vy[31];
          end
        endcase
      end
      default: ;
    endcase
  end

  assign prod_sh = prod_r >> FRAC_BITS;
  assign mq      = pneg_r ? -$signed(prod_sh) : $signed(prod_sh);
  assign ms      = sat32(mq);

  // pair differences
  assign sx = sat32($signed(64'(node_i_r.px)) - $signed(64'(nm_rd_r.px)));
  assign sy = sat32($signed(64'(node_i_r.py)) - $signed(64'(nm_rd_r.py)));

  // square root step
  assign sq_t   = sq_y_r + sq_bit_r;
  assign sq_ge  = (sq_x_r >= sq_t);
  assign sq_x_n = sq_ge ? (sq_x_r - sq_t) : sq_x_r;
  assign sq_y_n = sq_ge ? ((sq_y_r >> 1) + sq_bit_r) : (sq_y_r >> 1);

  // divider step
  assign rem_sh   = {rem_r[31:0], quo_r[DIV_W-1]};
  assign d_ge     = (rem_sh >= {1'b0, dist_r});
  assign rem_n    = d_ge ? (rem_sh - {1'b0, dist_r}) : rem_sh;
  assign quo_n    = {quo_r[DIV_W-2:0], d_ge};
  assign div_done = (div_cnt_r == DCW'(DIV_W - 1));
  assign q1c      = (quo_n > DIV_W'(64'd2147483648)) ? 32'h8000_0000 : quo_n[31:0];
  assign f2s      = sat32(rep_r[31] ? -$signed(64'(quo_n)) : $signed(64'(quo_n)));

  // spring terms
  assign dfs = sat32($signed({32'd0, dist_r}) - $signed({34'd0, edge_r.rest[30:1]}));
  assign f1s = sat32(-mq);
  assign f1v = edge_r.mark ? $signed(f1s[31:0]) : 32'sd0;
  assign tts = sat32($signed(64'(f1v)) + $signed(64'(f2_r)));

  assign axs = sat32($signed(64'(ax_acc_r)));
  assign ays = sat32($signed(64'(ay_acc_r)));

  // integration update
  always_comb begin
    case (iop_r)
      IOP_DT_X, IOP_ACC_X: irs_base = work_r.vx;
      IOP_DT_Y, IOP_ACC_Y: irs_base = work_r.vy;
      IOP_POS_X:           irs_base = work_r.px;
      default:             irs_base = work_r.py;
    endcase
  end
  assign irs = (iop_r == IOP_DT_X || iop_r == IOP_DT_Y)
             ? sat32($signed(64'(irs_base)) - $signed(64'($signed(ms[31:0]))))
             : sat32($signed(64'(irs_base)) + $signed(64'($signed(ms[31:0]))));

  // memory ports and next state
  always_comb begin
    state_nxt = state_r;
    nm_we     = 1'b0;
    em_we     = 1'b0;
    nm_waddr  = i_r;
    em_waddr  = clr_r;
    nm_wdata  = '0;
    em_wdata  = '0;
    nm_raddr  = i_r;
    em_raddr  = {i_r, j_r};
    case (state_r)
      ST_CLEAR: begin
        em_we    = 1'b1;
        nm_we    = (clr_r[EW-1:IW] == '0) && (32'(clr_r[IW-1:0]) < MAX_NODES);
        nm_waddr = clr_r[IW-1:0];
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        nm_raddr = IW'(in_node_index);
        if (in_acc) begin
          case (in_func)
            FN_WRITE_POS: begin
              nm_we       = ni_ok;
              nm_waddr    = IW'(in_node_index);
              nm_wdata.px = in_pos_x_in;
              nm_wdata.py = in_pos_y_in;
            end
            FN_WRITE_LEN: begin
              em_we         = ni_ok && pj_ok;
              em_waddr      = {IW'(in_node_index), IW'(in_peer_index)};
              em_wdata.mark = in_edge_present;
              em_wdata.rest = in_rest_len_in;
            end
            FN_READ: state_nxt = ST_RD_EMIT;
            default: state_nxt = ST_F_RDI;
          endcase
        end
      end
      ST_RD_EMIT: begin
        nm_raddr = IW'(req_node_r);
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_F_RDI:  state_nxt = ST_F_LATI;
      ST_F_LATI: state_nxt = ST_F_RDJ;
      ST_F_RDJ: begin
        nm_raddr = j_r;
        if (j_r == i_r) begin
          if (j_last) begin
            state_nxt = ST_F_WRI;
          end
        end else begin
          state_nxt = ST_F_DIFF;
        end
      end
      ST_F_DIFF: state_nxt = ST_F_SQX;
      ST_F_SQX:  state_nxt = ST_F_SQY;
      ST_F_SQY:  state_nxt = ST_F_SUM;
      ST_F_SUM:  state_nxt = ST_F_CHK;
      ST_F_CHK: begin
        if (d2_r != '0) begin
          state_nxt = ST_F_SQRT;
        end else begin
          state_nxt = j_last ? ST_F_WRI : ST_F_RDJ;
        end
      end
      ST_F_SQRT: begin
        if (sq_bit_r[0]) begin
          state_nxt = ST_F_DIV;
        end
      end
      ST_F_DIV: begin
        if (div_done && dop_r == DOP_UY) begin
          state_nxt = ST_F_SPDIF;
        end
      end
      ST_F_SPDIF: state_nxt = ST_F_SPMUL;
      ST_F_SPMUL: state_nxt = ST_F_SPRES;
      ST_F_SPRES: state_nxt = ST_F_AXMUL;
      ST_F_AXMUL: state_nxt = ST_F_AYMUL;
      ST_F_AYMUL: state_nxt = ST_F_AYRES;
      ST_F_AYRES: state_nxt = j_last ? ST_F_WRI : ST_F_RDJ;
      ST_F_WRI: begin
        nm_we       = 1'b1;
        nm_wdata    = node_i_r;
        nm_wdata.ax = axs[31:0];
        nm_wdata.ay = ays[31:0];
        nm_wdata.sat = fl_r | axs[32] | ays[32];
        state_nxt   = i_last ? ST_I_RD : ST_F_RDI;
      end
      ST_I_RD:  state_nxt = ST_I_DAT;
      ST_I_DAT: state_nxt = ST_I_MUL;
      ST_I_MUL: state_nxt = ST_I_RES;
      ST_I_RES: state_nxt = (iop_r == IOP_POS_Y) ? ST_I_EMIT : ST_I_MUL;
      ST_I_EMIT: begin
        if (out_free) begin
          nm_we     = 1'b1;
          nm_wdata  = work_r;
          state_nxt = i_last ? ST_IDLE : ST_I_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      nm_mem[nm_waddr] <= nm_wdata;
    end
    nm_rd_r <= nm_mem[nm_raddr];
    if (em_we) begin
      em_mem[em_waddr] <= em_wdata;
    end
    em_rd_r <= em_mem[em_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      nc_r    <= 7'd1;
      rep_r   <= '0;
      spr_r   <= '0;
      dt_r    <= '0;
      drag_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODE_COUNT: nc_r   <= cfg_data[6:0];
          CFG_REPULSION:  rep_r  <= cfg_data;
          CFG_SPRING:     spr_r  <= cfg_data;
          CFG_TIME_STEP:  dt_r   <= cfg_data[30:0];
          CFG_DRAG:       drag_r <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    pneg_r <= mul_neg;
    case (state_r)
      ST_IDLE: begin
        req_node_r <= in_node_index;
        req_ok_r   <= ni_ok;
        i_r        <= '0;
      end
      ST_F_LATI: begin
        node_i_r <= nm_rd_r;
        j_r      <= '0;
        ax_acc_r <= '0;
        ay_acc_r <= '0;
        fl_r     <= 1'b0;
      end
      ST_F_RDJ: begin
        if (j_r == i_r && !j_last) begin
          j_r <= j_r + 1'b1;
        end
      end
      ST_F_DIFF: begin
        dx_r   <= sx[31:0];
        dy_r   <= sy[31:0];
        fl_r   <= fl_r | sx[32] | sy[32];
        edge_r <= em_rd_r;
      end
      ST_F_SQY: d2_r <= prod_r;
      ST_F_SUM: d2_r <= d2_r + prod_r;
      ST_F_CHK: begin
        if (d2_r == '0) begin
          if (!j_last) begin
            j_r <= j_r + 1'b1;
          end
        end else begin
          sq_x_r   <= d2_r;
          sq_y_r   <= '0;
          sq_bit_r <= 64'd1 << 62;
        end
      end
      ST_F_SQRT: begin
        sq_x_r   <= sq_x_n;
        sq_y_r   <= sq_y_n;
        sq_bit_r <= sq_bit_r >> 2;
        if (sq_bit_r[0]) begin
          dist_r    <= sq_y_n[31:0];
          rem_r     <= '0;
          quo_r     <= {mag32(rep_r), {FRAC_BITS{1'b0}}};
          div_cnt_r <= '0;
          dop_r     <= DOP_Q1;
        end
      end
      ST_F_DIV: begin
        if (div_done) begin
          rem_r     <= '0;
          div_cnt_r <= '0;
          case (dop_r)
            DOP_Q1: begin
              quo_r <= {q1c, {FRAC_BITS{1'b0}}};
              dop_r <= DOP_Q2;
            end
            DOP_Q2: begin
              f2_r  <= f2s[31:0];
              fl_r  <= fl_r | f2s[32];
              quo_r <= {mag32(dx_r), {FRAC_BITS{1'b0}}};
              dop_r <= DOP_UX;
            end
            DOP_UX: begin
              ux_r  <= quo_n[UNIT_W-1:0];
              quo_r <= {mag32(dy_r), {FRAC_BITS{1'b0}}};
              dop_r <= DOP_UY;
            end
            default: uy_r <= quo_n[UNIT_W-1:0];
          endcase
        end else begin
          rem_r     <= rem_n;
          quo_r     <= quo_n;
          div_cnt_r <= div_cnt_r + 1'b1;
        end
      end
      ST_F_SPDIF: begin
        diff_r <= dfs[31:0];
        fl_r   <= fl_r | (edge_r.mark & dfs[32]);
      end
      ST_F_SPRES: begin
        tot_r <= tts[31:0];
        fl_r  <= fl_r | tts[32] | (edge_r.mark & f1s[32]);
      end
      ST_F_AYMUL: ax_acc_r <= ax_acc_r + ACC_W'(mq);
      ST_F_AYRES: begin
        ay_acc_r <= ay_acc_r + ACC_W'(mq);
        if (!j_last) begin
          j_r <= j_r + 1'b1;
        end
      end
      ST_F_WRI: i_r <= i_last ? '0 : i_r + 1'b1;
      ST_I_DAT: begin
        work_r <= nm_rd_r;
        iop_r  <= IOP_DRAG_X;
      end
      ST_I_RES: begin
        iop_r <= iop_r + 3'd1;
        case (iop_r)
          IOP_DRAG_X, IOP_DRAG_Y: begin
            tmp_r      <= ms[31:0];
            work_r.sat <= work_r.sat | ms[32];
          end
          IOP_DT_X, IOP_ACC_X: begin
            work_r.vx  <= irs[31:0];
            work_r.sat <= work_r.sat | ms[32] | irs[32];
          end
          IOP_DT_Y, IOP_ACC_Y: begin
            work_r.vy  <= irs[31:0];
            work_r.sat <= work_r.sat | ms[32] | irs[32];
          end
          IOP_POS_X: begin
            work_r.px  <= irs[31:0];
            work_r.sat <= work_r.sat | ms[32] | irs[32];
          end
          default: begin
            work_r.py  <= irs[31:0];
            work_r.sat <= work_r.sat | ms[32] | irs[32];
          end
        endcase
      end
      ST_I_EMIT: begin
        if (out_free && !i_last) begin
          i_r <= i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      if (state_r == ST_RD_EMIT) begin
        out_node_r <= req_node_r;
        out_px_r   <= req_ok_r ? nm_rd_r.px : 32'sd0;
        out_py_r   <= req_ok_r ? nm_rd_r.py : 32'sd0;
        out_sat_r  <= 1'b0;
        out_last_r <= 1'b1;
      end else begin
        out_node_r <= 6'(i_r);
        out_px_r   <= work_r.px;
        out_py_r   <= work_r.py;
        out_sat_r  <= work_r.sat;
        out_last_r <= i_last;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_node      = out_node_r;
  assign out_pos_x_out = out_px_r;
  assign out_pos_y_out = out_py_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_F_DIV |-> dist_r != '0)
    else $error("divide by zero distance");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_F_DIV && dop_r == DOP_Q1 && div_cnt_r == '0) |->
      (64'(dist_r) * 64'(dist_r) <= d2_r) &&
      ((64'(dist_r) + 64'd1) * (64'(dist_r) + 64'd1) > d2_r))
    else $error("square root out of range");

  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_F_SPDIF |->
      (ux_r <= UNIT_W'(1 << FRAC_BITS)) && (uy_r <= UNIT_W'(1 << FRAC_BITS)))
    else $error("unit vector component above one");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_I_EMIT || state_r == ST_RD_EMIT))
    else $error("result transfer without emit");

endmodule

FILE: sim/force_directed_layout_step_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for force_directed_layout_step: directed, random and backpressure
// tests against a built-in layout predictor. Depends on fdl_pkg and the block's RTL.
module force_directed_layout_step_tb;
  import fdl_pkg::*;

  localparam int NODES = 64;
  localparam int STALL_LIMIT = 200000;

  typedef struct {
    bit [5:0]  node;
    bit [31:0] x;
    bit [31:0] y;
    bit        sat;
    bit        last;
  } pos_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = '0;
  logic [5:0]         in_node_index = '0;
  logic [5:0]         in_peer_index = '0;
  logic signed [31:0] in_pos_x_in = '0;
  logic signed [31:0] in_pos_y_in = '0;
  logic [30:0]        in_rest_len_in = '0;
  logic               in_edge_present = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_node;
  logic signed [31:0] out_pos_x_out;
  logic signed [31:0] out_pos_y_out;
  logic               out_saturated;
  logic               out_last;

  pos_report_t pos_q[$];
  int          errors = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  // layout state mirror
  int unsigned       m_count;
  longint            m_rep, m_spring, m_dt, m_drag;
  longint            px[NODES], py[NODES], vx[NODES], vy[NODES], ax[NODES], ay[NODES];
  int unsigned       rest_len[NODES*NODES];
  bit                edge_mark[NODES*NODES];

  always #5 clk = ~clk;

  force_directed_layout_step i_dut (.*);

  function automatic longint sat_q(longint v, inout bit fl);
    if (v > 64'sd2147483647) begin
      fl = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      fl = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned mag_q(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint unsigned m;
    m = (mag_q(a) * mag_q(b)) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_q(longint a, longint unsigned d);
    longint unsigned m;
    m = (mag_q(a) << FRAC_BITS) / d;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_q(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint pair_force(longint span, int i, int j, inout bit fl);
    longint unsigned q;
    longint f1, f2, half, diff;
    f1 = 0;
    q = (mag_q(m_rep) << FRAC_BITS) / longint'(span);
    if (q > (64'd1 << 31)) q = 64'd1 << 31;
    q = (q << FRAC_BITS) / longint'(span);
    f2 = sat_q(m_rep < 0 ? -longint'(q) : longint'(q), fl);
    if (edge_mark[i*NODES+j]) begin
      half = rest_len[i*NODES+j] >> 1;
      diff = sat_q(span - half, fl);
      f1 = sat_q(-mul_q(m_spring, diff), fl);
    end
    return sat_q(f1 + f2, fl);
  endfunction

  function automatic void predict_step();
    int n;
    bit satf[NODES];
    longint sx, sy, dx, dy, span, tot, t;
    longint unsigned d2;
    bit fl;
    pos_report_t r;
    n = m_count < 1 ? 1 : (m_count > NODES ? NODES : m_count);
    for (int i = 0; i < n; i++) begin
      sx = 0;
      sy = 0;
      fl = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (i == j) continue;
        dx = sat_q(px[i] - px[j], fl);
        dy = sat_q(py[i] - py[j], fl);
        d2 = longint'(dx * dx) + longint'(dy * dy);
        if (d2 == 0) continue;
        span = root_q(d2);
        tot = pair_force(span, i, j, fl);
        sx += mul_q(div_q(dx, span), tot);
        sy += mul_q(div_q(dy, span), tot);
      end
      ax[i] = sat_q(sx, fl);
      ay[i] = sat_q(sy, fl);
      satf[i] = fl;
    end
    for (int i = 0; i < n; i++) begin
      fl = satf[i];
      t = sat_q(mul_q(sat_q(mul_q(m_drag, vx[i]), fl), m_dt), fl);
      vx[i] = sat_q(vx[i] - t, fl);
      t = sat_q(mul_q(sat_q(mul_q(m_drag, vy[i]), fl), m_dt), fl);
      vy[i] = sat_q(vy[i] - t, fl);
      satf[i] = fl;
    end
    for (int i = 0; i < n; i++) begin
      fl = satf[i];
      vx[i] = sat_q(vx[i] + sat_q(mul_q(ax[i], m_dt), fl), fl);
      vy[i] = sat_q(vy[i] + sat_q(mul_q(ay[i], m_dt), fl), fl);
      px[i] = sat_q(px[i] + sat_q(mul_q(vx[i], m_dt), fl), fl);
      py[i] = sat_q(py[i] + sat_q(mul_q(vy[i], m_dt), fl), fl);
      r.node = 6'(i);
      r.x = px[i][31:0];
      r.y = py[i][31:0];
      r.sat = fl;
      r.last = (i == n - 1);
      pos_q.push_back(r);
    end
  endfunction

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NODE_COUNT: m_count = data[6:0];
      CFG_REPULSION:  m_rep = longint'(signed'(data));
      CFG_SPRING:     m_spring = longint'(signed'(data));
      CFG_TIME_STEP:  m_dt = data[30:0];
      CFG_DRAG:       m_drag = data[30:0];
      default: ;
    endcase
  endtask

  task automatic send(func_t f, bit [5:0] ni, bit [5:0] pj, logic signed [31:0] x,
                      logic signed [31:0] y, bit [30:0] len, bit e);
    pos_report_t r;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_node_index <= ni;
    in_peer_index <= pj;
    in_pos_x_in <= x;
    in_pos_y_in <= y;
    in_rest_len_in <= len;
    in_edge_present <= e;
    do @(posedge clk); while (in_stall);
    case (f)
      FN_WRITE_POS: begin
        px[ni] = x;
        py[ni] = y;
        vx[ni] = 0;
        vy[ni] = 0;
        ax[ni] = 0;
        ay[ni] = 0;
      end
      FN_WRITE_LEN: begin
        rest_len[ni*NODES+pj] = len;
        edge_mark[ni*NODES+pj] = e;
      end
      FN_READ: begin
        r.node = ni;
        r.x = px[ni][31:0];
        r.y = py[ni][31:0];
        r.sat = 1'b0;
        r.last = 1'b1;
        pos_q.push_back(r);
      end
      default: predict_step();
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pos_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_pos();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(1 << 22) * ($urandom_range(1) ? 1 : -1);
  endfunction

  task automatic test_directed();
    write_cfg(CFG_NODE_COUNT, 32'd0);
    send(FN_READ, 6'd0, 6'd0, 0, 0, 0, 1'b0);
    send(FN_STEP, 6'd0, 6'd0, 0, 0, 0, 1'b0);
    send(FN_WRITE_POS, 6'd63, 6'd0, 32'sh7FFF_FFFF, -32'sh8000_0000, 0, 1'b0);
    send(FN_READ, 6'd63, 6'd63, 0, 0, 0, 1'b0);
    send(FN_WRITE_LEN, 6'd63, 6'd63, 0, 0, 31'h7FFF_FFFF, 1'b1);
    drain();
    write_cfg(CFG_NODE_COUNT, 32'd127);
    write_cfg(CFG_REPULSION, 32'h7FFF_FFFF);
    write_cfg(CFG_SPRING, 32'h8000_0000);
    write_cfg(CFG_TIME_STEP, 32'h7FFF_FFFF);
    write_cfg(CFG_DRAG, 32'h7FFF_FFFF);
    send(FN_READ, 6'd63, 6'd0, 0, 0, 0, 1'b0);
    drain();
    write_cfg(CFG_NODE_COUNT, 32'd64);
    send(FN_READ, 6'd5, 6'd0, 0, 0, 0, 1'b0);
    drain();
    // extreme positions and full-range constants: saturation everywhere
    write_cfg(CFG_NODE_COUNT, 32'd3);
    send(FN_WRITE_POS, 6'd0, 6'd0, -32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b0);
    send(FN_WRITE_POS, 6'd1, 6'd0, 32'sh7FFF_FFFF, -32'sh8000_0000, 0, 1'b0);
    send(FN_WRITE_POS, 6'd2, 6'd0, 32'sh7FFF_FFFF, -32'sh8000_0000, 0, 1'b0);
    send(FN_WRITE_LEN, 6'd0, 6'd1, 0, 0, 31'h7FFF_FFFF, 1'b1);
    send(FN_WRITE_LEN, 6'd1, 6'd0, 0, 0, 31'd0, 1'b1);
    send(FN_STEP, 6'd0, 6'd0, 0, 0, 0, 1'b0);
    send(FN_STEP, 6'd0, 6'd0, 0, 0, 0, 1'b0);
    drain();
    write_cfg(CFG_REPULSION, 32'h8000_0000);
    write_cfg(CFG_SPRING, 32'h7FFF_FFFF);
    write_cfg(CFG_TIME_STEP, 32'd0);
    write_cfg(CFG_DRAG, 32'd0);
    send(FN_WRITE_POS, 6'd0, 6'd0, 32'sh0001_0000, 32'sh0002_0000, 0, 1'b0);
    send(FN_WRITE_LEN, 6'd1, 6'd0, 0, 0, 31'h0001_0000, 1'b0);
    send(FN_STEP, 6'd0, 6'd0, 0, 0, 0, 1'b0);
    drain();
  endtask

  task automatic test_random(int items);
    int n, pick;
    write_cfg(CFG_NODE_COUNT, $urandom_range(2, 6));
    write_cfg(CFG_REPULSION, $urandom_range(5) == 0 ? $urandom
              : $urandom_range(1 << 24) * ($urandom_range(1) ? 1 : -1));
    write_cfg(CFG_SPRING, $urandom_range(5) == 0 ? $urandom
              : $urandom_range(1 << 18) * ($urandom_range(1) ? 1 : -1));
    write_cfg(CFG_TIME_STEP, $urandom_range(5) == 0 ? $urandom : $urandom_range(1 << 16));
    write_cfg(CFG_DRAG, $urandom_range(5) == 0 ? $urandom : $urandom_range(1 << 15));
    n = m_count;
    for (int k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send(FN_WRITE_POS,
             6'($urandom_range(7) == 0 ? $urandom_range(63) : $urandom_range(n - 1)),
             6'($urandom), rand_pos(), rand_pos(), 31'($urandom), 1'($urandom));
      end else if (pick < 55) begin
        send(FN_WRITE_LEN, 6'($urandom_range(n - 1)),
             6'($urandom_range(7) == 0 ? $urandom_range(63) : $urandom_range(n - 1)),
             $urandom, $urandom,
             31'($urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 21)),
             $urandom_range(9) < 7);
      end else if (pick < 70) begin
        send(FN_STEP, 6'($urandom), 6'($urandom), $urandom, $urandom, 31'($urandom),
             1'($urandom));
      end else begin
        send(FN_READ, 6'($urandom_range(63)), 6'($urandom), $urandom, $urandom,
             31'($urandom), 1'($urandom));
      end
    end
    drain();
  endtask

  task automatic test_pressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_left = 3000;
    for (int k = 0; k < 20; k++)
      send(FN_READ, 6'($urandom_range(63)), 6'd0, 0, 0, 0, 1'b0);
    send(FN_STEP, 6'd0, 6'd0, 0, 0, 0, 1'b0);
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= $urandom_range(99) < out_stall_pct;
    end
  end

  always @(posedge clk) begin
    pos_report_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (pos_q.size() == 0) begin
        $error("unexpected result transfer for node %0d", out_node);
        errors++;
      end else begin
        r = pos_q.pop_front();
        if (out_node !== r.node) begin
          $error("out_node: expected %0d, got %0d", r.node, out_node);
          errors++;
        end
        if (out_pos_x_out !== r.x) begin
          $error("pos_x_out: expected %h, got %h", r.x, out_pos_x_out);
          errors++;
        end
        if (out_pos_y_out !== r.y) begin
          $error("pos_y_out: expected %h, got %h", r.y, out_pos_y_out);
          errors++;
        end
        if (out_saturated !== r.sat) begin
          $error("saturated: expected %0d, got %0d", r.sat, out_saturated);
          errors++;
        end
        if (out_last !== r.last) begin
          $error("last: expected %0d, got %0d", r.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    m_count = 1;
    m_rep = 0;
    m_spring = 0;
    m_dt = 0;
    m_drag = 0;
    for (int i = 0; i < NODES; i++) begin
      px[i] = 0;
      py[i] = 0;
      vx[i] = 0;
      vy[i] = 0;
      ax[i] = 0;
      ay[i] = 0;
    end
    for (int i = 0; i < NODES*NODES; i++) begin
      rest_len[i] = 0;
      edge_mark[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    in_idle_pct = 0;
    out_stall_pct = 0;
    test_random(15);
    in_idle_pct = 85;
    out_stall_pct = 0;
    test_random(15);
    in_idle_pct = 0;
    out_stall_pct = 85;
    test_random(15);
    in_idle_pct = 24;
    out_stall_pct = 24;
    test_random(15);
    test_pressure();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
